>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> rtl/untenc_pkg.sv
`timescale 1ns / 1ps

package untenc_pkg;

  // Storage sizes
  localparam int unsigned MaxUriChars   = 256;
  localparam int unsigned MaxComponents = 128;

  localparam int unsigned CharIdxW = (MaxUriChars > 1) ? $clog2(MaxUriChars) : 1;
  localparam int unsigned CharCntW = $clog2(MaxUriChars + 1);
  localparam int unsigned CompIdxW = (MaxComponents > 1) ? $clog2(MaxComponents) : 1;
  localparam int unsigned CompCntW = $clog2(MaxComponents + 1);
  localparam int unsigned CurLenW  = 8;
  // encoded name body never exceeds a few hundred bytes
  localparam int unsigned TotW     = 10;
  localparam int unsigned SpaceW   = 10;
  localparam int unsigned PAddrW   = 4;
  localparam int unsigned PDataW   = 32;
  localparam int unsigned WordBytes = 8;

  // Characters and TLV markers
  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] VarMarker   = 8'hFD;
  localparam logic [TotW-1:0] VarLimit = TotW'(253);

  // Register reset values
  localparam logic [7:0]        NameTypeRst = 8'd7;
  localparam logic [7:0]        CompTypeRst = 8'd8;
  localparam logic [SpaceW-1:0] SpaceRst    = SpaceW'(1023);

  typedef enum logic [1:0] {
    RegNameType = 2'd0,
    RegCompType = 2'd1,
    RegSpace    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] uri_char;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        last_word;
    logic        status;
  } out_beat_t;

  typedef enum logic [1:0] {
    TokByte,
    TokFlush,
    TokFail
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;
  } tok_t;

  // Summary of a parsed URI, handed from parser to emitter
  typedef struct packed {
    logic                fail;
    logic [TotW-1:0]     total;
    logic [CompCntW-1:0] comp_count;
  } job_t;

  typedef struct packed {
    logic [7:0]        name_type;
    logic [7:0]        comp_type;
    logic [SpaceW-1:0] space;
  } cfg_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) v = c - 8'h30;
    else if ((c >= 8'h61) && (c <= 8'h66)) v = c - 8'h57;
    else if ((c >= 8'h41) && (c <= 8'h46)) v = c - 8'h37;
    return v[3:0];
  endfunction

  // Bytes of one component TLV: type, length field, value
  function automatic logic [TotW-1:0] comp_size(input logic [CurLenW-1:0] len);
    logic [TotW-1:0] ext;
    ext = TotW'(len);
    return (ext < VarLimit) ? ext + TotW'(2) : ext + TotW'(4);
  endfunction

  // Bytes of the whole name TLV
  function automatic logic [TotW:0] name_size(input logic [TotW-1:0] total);
    logic [TotW:0] ext;
    ext = {1'b0, total};
    return (total < VarLimit) ? ext + (TotW+1)'(2) : ext + (TotW+1)'(4);
  endfunction

endpackage

>>> rtl/uri_name_to_tlv_encoder_core.sv
`timescale 1ns / 1ps

// Name URI to TLV encoder. Characters of a slash-separated URI arrive one
// beat per cycle while in_stall_o is low (the last flagged) and are checked
// and written into a 256-entry character memory, while closing slashes and
// the end of the URI write each component's length into a 128-entry length
// memory. After the last beat the input stalls through closing, size check
// and hand-off, then a sequencer reads both memories back through their
// registered read ports and packs the TLV name into 8-byte output beats; a
// malformed, oversized or unfittable URI yields a single failure beat
// instead. The input stays stalled after the last beat until the whole name
// has been emitted, including any time the output is held off.
// Type and space registers sit on an APB port at byte addresses 0, 4 and 8.
module uri_name_to_tlv_encoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  untenc_pkg::in_beat_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output untenc_pkg::out_beat_t         out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [untenc_pkg::PAddrW-1:0] paddr,
  input  logic [untenc_pkg::PDataW-1:0] pwdata,
  output logic [untenc_pkg::PDataW-1:0] prdata,
  output logic                          pready
);
  import untenc_pkg::*;

  cfg_t                cfg_q;
  reg_idx_e            reg_idx;
  logic                char_we;
  logic [CharIdxW-1:0] char_waddr;
  logic [7:0]          char_wdata;
  logic [CharIdxW-1:0] char_raddr;
  logic [7:0]          char_rdata;
  logic                len_we;
  logic [CompIdxW-1:0] len_waddr;
  logic [CurLenW-1:0]  len_wdata;
  logic [CompIdxW-1:0] len_raddr;
  logic [CurLenW-1:0]  len_rdata;
  logic                start;
  job_t                job;
  logic                done;
  logic                tok_valid;
  logic                tok_ready;
  tok_t                tok;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{name_type: NameTypeRst, comp_type: CompTypeRst, space: SpaceRst};
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        RegNameType: cfg_q.name_type <= pwdata[7:0];
        RegCompType: cfg_q.comp_type <= pwdata[7:0];
        RegSpace:    cfg_q.space     <= pwdata[SpaceW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegNameType: prdata = PDataW'(cfg_q.name_type);
      RegCompType: prdata = PDataW'(cfg_q.comp_type);
      RegSpace:    prdata = PDataW'(cfg_q.space);
      default:     prdata = '0;
    endcase
  end

  // Input checking and store writes
  untenc_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .space_i      (cfg_q.space),
    .char_we_o    (char_we),
    .char_waddr_o (char_waddr),
    .char_wdata_o (char_wdata),
    .len_we_o     (len_we),
    .len_waddr_o  (len_waddr),
    .len_wdata_o  (len_wdata),
    .start_o      (start),
    .job_o        (job),
    .done_i       (done)
  );

  // Character and component length memories
  untenc_ram #(
    .Depth (MaxUriChars),
    .DataW (8)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (char_we),
    .waddr_i (char_waddr),
    .wdata_i (char_wdata),
    .raddr_i (char_raddr),
    .rdata_o (char_rdata)
  );

  untenc_ram #(
    .Depth (MaxComponents),
    .DataW (CurLenW)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // Readback sequencer
  untenc_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .job_i        (job),
    .name_type_i  (cfg_q.name_type),
    .comp_type_i  (cfg_q.comp_type),
    .char_raddr_o (char_raddr),
    .char_rdata_i (char_rdata),
    .len_raddr_o  (len_raddr),
    .len_rdata_i  (len_rdata),
    .tok_valid_o  (tok_valid),
    .tok_ready_i  (tok_ready),
    .tok_o        (tok),
    .done_o       (done)
  );

  // Word packing and output register
  untenc_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_ready_o (tok_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/untenc_ram.sv
`timescale 1ns / 1ps

module untenc_ram #(
  parameter int unsigned  Depth = 256,
  parameter int unsigned  DataW = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/untenc_parse.sv
`timescale 1ns / 1ps

module untenc_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  untenc_pkg::in_beat_t          in_data_i,
  input  logic [untenc_pkg::SpaceW-1:0] space_i,
  output logic                          char_we_o,
  output logic [untenc_pkg::CharIdxW-1:0] char_waddr_o,
  output logic [7:0]                    char_wdata_o,
  output logic                          len_we_o,
  output logic [untenc_pkg::CompIdxW-1:0] len_waddr_o,
  output logic [untenc_pkg::CurLenW-1:0]  len_wdata_o,
  output logic                          start_o,
  output untenc_pkg::job_t              job_o,
  input  logic                          done_i
);
  import untenc_pkg::*;

  typedef enum logic [2:0] {
    P_LOAD,
    P_CLOSE,
    P_CHECK,
    P_START,
    P_WAIT
  } parse_state_e;

  typedef enum logic [1:0] {
    EscNone,
    EscFirst,
    EscSecond
  } esc_e;

  parse_state_e        state_q, state_d;
  logic [CharCntW-1:0] count_q, count_d;
  logic [CurLenW-1:0]  cur_q, cur_d;
  logic [CompCntW-1:0] comps_q, comps_d;
  logic [TotW-1:0]     total_q, total_d;
  esc_e                esc_q, esc_d;
  logic                err_q, err_d;
  logic                close_req;
  logic [7:0]          c;

  assign c = in_data_i.uri_char;

  // Character checks, component close and final size check
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cur_d     = cur_q;
    comps_d   = comps_q;
    total_d   = total_q;
    esc_d     = esc_q;
    err_d     = err_q;
    close_req = 1'b0;
    char_we_o = 1'b0;
    len_we_o  = 1'b0;

    unique case (state_q)
      P_LOAD: begin
        if (in_valid_i) begin
          if (!err_q) begin
            if (count_q >= CharCntW'(MaxUriChars)) begin
              err_d = 1'b1;
            end else begin
              char_we_o = 1'b1;
              count_d   = count_q + CharCntW'(1);
              if (count_q == '0) begin
                if (c != CharSlash) err_d = 1'b1;
              end else if (esc_q != EscNone) begin
                if (!is_hex(c)) err_d = 1'b1;
                else esc_d = (esc_q == EscFirst) ? EscSecond : EscNone;
              end else if (c == CharSlash) begin
                if (cur_q == '0) err_d = 1'b1;
                else close_req = 1'b1;
              end else begin
                if (cur_q == '1) err_d = 1'b1;
                else cur_d = cur_q + CurLenW'(1);
                if (c == CharPercent) esc_d = EscFirst;
              end
            end
          end
          if (in_data_i.last_char) state_d = P_CLOSE;
        end
      end
      P_CLOSE: begin
        // URI ended inside an escape, or a final component is still open
        if (esc_q != EscNone) err_d = 1'b1;
        else if (!err_q && (cur_q != '0)) close_req = 1'b1;
        state_d = P_CHECK;
      end
      P_CHECK: begin
        if (!err_q && (name_size(total_q) > {1'b0, space_i})) err_d = 1'b1;
        state_d = P_START;
      end
      P_START: begin
        state_d = P_WAIT;
      end
      P_WAIT: begin
        if (done_i) begin
          count_d = '0;
          cur_d   = '0;
          comps_d = '0;
          total_d = '0;
          esc_d   = EscNone;
          err_d   = 1'b0;
          state_d = P_LOAD;
        end
      end
      default: state_d = P_LOAD;
    endcase

    // component close: record its length and grow the name length
    if (close_req) begin
      if (comps_q >= CompCntW'(MaxComponents)) begin
        err_d = 1'b1;
      end else begin
        len_we_o = 1'b1;
        comps_d  = comps_q + CompCntW'(1);
        total_d  = total_q + comp_size(cur_q);
        cur_d    = '0;
      end
    end
  end

  assign char_waddr_o = count_q[CharIdxW-1:0];
  assign char_wdata_o = c;
  assign len_waddr_o  = comps_q[CompIdxW-1:0];
  assign len_wdata_o  = cur_q;
  assign in_stall_o   = (state_q != P_LOAD);
  assign start_o      = (state_q == P_START);
  assign job_o        = '{fail: err_q, total: total_q, comp_count: comps_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_LOAD;
      count_q <= '0;
      cur_q   <= '0;
      comps_q <= '0;
      total_q <= '0;
      esc_q   <= EscNone;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      comps_q <= comps_d;
      total_q <= total_d;
      esc_q   <= esc_d;
      err_q   <= err_d;
    end
  end

endmodule

>>> rtl/untenc_emit.sv
`timescale 1ns / 1ps

module untenc_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  untenc_pkg::job_t                job_i,
  input  logic [7:0]                      name_type_i,
  input  logic [7:0]                      comp_type_i,
  output logic [untenc_pkg::CharIdxW-1:0] char_raddr_o,
  input  logic [7:0]                      char_rdata_i,
  output logic [untenc_pkg::CompIdxW-1:0] len_raddr_o,
  input  logic [untenc_pkg::CurLenW-1:0]  len_rdata_i,
  output logic                            tok_valid_o,
  input  logic                            tok_ready_i,
  output untenc_pkg::tok_t                tok_o,
  output logic                            done_o
);
  import untenc_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE,
    E_FAIL,
    E_NTYPE,
    E_VAR,
    E_COMP,
    E_CLEN,
    E_CTYPE,
    E_CHAR,
    E_CRD,
    E_EW1,
    E_EHI,
    E_EW2,
    E_ELO,
    E_FLUSH
  } emit_state_e;

  emit_state_e         state_q, state_d;
  job_t                job_q, job_d;
  logic [TotW-1:0]     var_val_q, var_val_d;
  logic [1:0]          var_step_q, var_step_d;
  logic                var_comp_q, var_comp_d;
  logic [CompCntW-1:0] idx_q, idx_d;
  logic [CurLenW-1:0]  len_q, len_d;
  logic [CharCntW-1:0] k_q, k_d;
  logic [3:0]          hi_q, hi_d;
  logic                done_q, done_d;
  logic                var_short;

  assign var_short = (var_val_q < VarLimit);

  // Byte sequencer over the two stores
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    var_val_d   = var_val_q;
    var_step_d  = var_step_q;
    var_comp_d  = var_comp_q;
    idx_d       = idx_q;
    len_d       = len_q;
    k_d         = k_q;
    hi_d        = hi_q;
    done_d      = 1'b0;
    tok_valid_o = 1'b0;
    tok_o       = '{kind: TokByte, data: 8'd0};

    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          job_d   = job_i;
          k_d     = CharCntW'(1);
          idx_d   = '0;
          state_d = job_i.fail ? E_FAIL : E_NTYPE;
        end
      end
      E_FAIL: begin
        tok_valid_o = 1'b1;
        tok_o.kind  = TokFail;
        if (tok_ready_i) begin
          done_d  = 1'b1;
          state_d = E_IDLE;
        end
      end
      E_NTYPE: begin
        tok_valid_o = 1'b1;
        tok_o.data  = name_type_i;
        if (tok_ready_i) begin
          var_val_d  = job_q.total;
          var_step_d = 2'd0;
          var_comp_d = 1'b0;
          state_d    = E_VAR;
        end
      end
      E_VAR: begin
        // one byte below 253, else marker and two bytes big-endian
        tok_valid_o = 1'b1;
        case (var_step_q)
          2'd0:    tok_o.data = var_short ? var_val_q[7:0] : VarMarker;
          2'd1:    tok_o.data = 8'(var_val_q >> 8);
          default: tok_o.data = var_val_q[7:0];
        endcase
        if (tok_ready_i) begin
          if (((var_step_q == 2'd0) && var_short) || (var_step_q == 2'd2)) begin
            state_d = var_comp_q ? E_CHAR : E_COMP;
          end else begin
            var_step_d = var_step_q + 2'd1;
          end
        end
      end
      E_COMP: begin
        state_d = (idx_q == job_q.comp_count) ? E_FLUSH : E_CLEN;
      end
      E_CLEN: begin
        len_d   = len_rdata_i;
        state_d = E_CTYPE;
      end
      E_CTYPE: begin
        tok_valid_o = 1'b1;
        tok_o.data  = comp_type_i;
        if (tok_ready_i) begin
          var_val_d  = TotW'(len_q);
          var_step_d = 2'd0;
          var_comp_d = 1'b1;
          state_d    = E_VAR;
        end
      end
      E_CHAR: begin
        if (len_q == '0) begin
          // skip the separating slash
          k_d     = k_q + CharCntW'(1);
          idx_d   = idx_q + CompCntW'(1);
          state_d = E_COMP;
        end else begin
          state_d = E_CRD;
        end
      end
      E_CRD: begin
        if (char_rdata_i == CharPercent) begin
          k_d     = k_q + CharCntW'(1);
          state_d = E_EW1;
        end else begin
          tok_valid_o = 1'b1;
          tok_o.data  = char_rdata_i;
          if (tok_ready_i) begin
            k_d     = k_q + CharCntW'(1);
            len_d   = len_q - CurLenW'(1);
            state_d = E_CHAR;
          end
        end
      end
      E_EW1: begin
        state_d = E_EHI;
      end
      E_EHI: begin
        hi_d    = hex_value(char_rdata_i);
        k_d     = k_q + CharCntW'(1);
        state_d = E_EW2;
      end
      E_EW2: begin
        state_d = E_ELO;
      end
      E_ELO: begin
        tok_valid_o = 1'b1;
        tok_o.data  = {hi_q, hex_value(char_rdata_i)};
        if (tok_ready_i) begin
          k_d     = k_q + CharCntW'(1);
          len_d   = len_q - CurLenW'(1);
          state_d = E_CHAR;
        end
      end
      E_FLUSH: begin
        tok_valid_o = 1'b1;
        tok_o.kind  = TokFlush;
        if (tok_ready_i) begin
          done_d  = 1'b1;
          state_d = E_IDLE;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  assign char_raddr_o = k_q[CharIdxW-1:0];
  assign len_raddr_o  = idx_q[CompIdxW-1:0];
  assign done_o       = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= E_IDLE;
      job_q      <= '0;
      var_val_q  <= '0;
      var_step_q <= 2'd0;
      var_comp_q <= 1'b0;
      idx_q      <= '0;
      len_q      <= '0;
      k_q        <= '0;
      hi_q       <= 4'd0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      job_q      <= job_d;
      var_val_q  <= var_val_d;
      var_step_q <= var_step_d;
      var_comp_q <= var_comp_d;
      idx_q      <= idx_d;
      len_q      <= len_d;
      k_q        <= k_d;
      hi_q       <= hi_d;
      done_q     <= done_d;
    end
  end

endmodule

>>> rtl/untenc_pack.sv
`timescale 1ns / 1ps

module untenc_pack (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tok_valid_i,
  input  untenc_pkg::tok_t      tok_i,
  output logic                  tok_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output untenc_pkg::out_beat_t out_data_o
);
  import untenc_pkg::*;

  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_data_q, out_data_d;
  logic        out_free;
  logic        need_emit;

  // A full word is held back until the next byte shows it is not the last.
  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    need_emit   = (tok_i.kind != TokByte) || (cnt_q == 4'(WordBytes));
    tok_ready_o = !need_emit || out_free;

    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    if (tok_valid_i && tok_ready_o) begin
      case (tok_i.kind)
        TokByte: begin
          if (cnt_q == 4'(WordBytes)) begin
            out_valid_d = 1'b1;
            out_data_d  = '{out_word: acc_q, byte_count: cnt_q,
                            last_word: 1'b0, status: 1'b0};
            acc_d       = 64'(tok_i.data);
            cnt_d       = 4'd1;
          end else begin
            acc_d[{cnt_q[2:0], 3'b000} +: 8] = tok_i.data;
            cnt_d = cnt_q + 4'd1;
          end
        end
        TokFlush: begin
          out_valid_d = 1'b1;
          out_data_d  = '{out_word: acc_q, byte_count: cnt_q,
                          last_word: 1'b1, status: 1'b0};
          acc_d       = '0;
          cnt_d       = 4'd0;
        end
        TokFail: begin
          out_valid_d = 1'b1;
          out_data_d  = '{out_word: 64'd0, byte_count: 4'd0,
                          last_word: 1'b1, status: 1'b1};
          acc_d       = '0;
          cnt_d       = 4'd0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule

>>> rtl/untenc_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module untenc_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input untenc_pkg::in_beat_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input untenc_pkg::out_beat_t out_data_o
);
  import untenc_pkg::*;

  // a failure beat is empty and closes the URI
  `ASSERT_IMP(a_fail_shape, out_valid_o && out_data_o.status, out_data_o.last_word && (out_data_o.byte_count == 4'd0) && (out_data_o.out_word == 64'd0))

  // only the closing beat of a name may be partly filled
  `ASSERT_IMP(a_mid_full, out_valid_o && !out_data_o.last_word, (out_data_o.byte_count == 4'd8) && !out_data_o.status)

  // a good beat carries one to eight bytes
  `ASSERT_IMP(a_ok_count, out_valid_o && !out_data_o.status, (out_data_o.byte_count != 4'd0) && (out_data_o.byte_count <= 4'd8))

  // the closing character starts the encode pass and blocks new input
  `ASSERT_NXT(a_last_blocks, in_valid_i && !in_stall_o && in_data_i.last_char, in_stall_o)

  // stalled output beat holds
  `ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind uri_name_to_tlv_encoder_core untenc_checker u_checker (.*);

>>> tb/sv/uri_name_to_tlv_encoder_core_tb.sv
`timescale 1ns / 1ps

module uri_name_to_tlv_encoder_core_tb;
  import untenc_pkg::*;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 10;

  typedef logic [7:0] text_t[$];
  typedef enum logic [1:0] {EscNone, EscFirst, EscSecond} esc_e;

  // DUT ports, all driven to known values from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_beat_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_beat_t         out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PAddrW-1:0] paddr       = '0;
  logic [PDataW-1:0] pwdata      = '0;
  logic [PDataW-1:0] prdata;
  logic              pready;

  uri_name_to_tlv_encoder_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk_i = ~clk_i;

  // Shadow registers
  logic [7:0]        name_type_cfg = NameTypeRst;
  logic [7:0]        comp_type_cfg = CompTypeRst;
  logic [SpaceW-1:0] space_cfg     = SpaceRst;

  // Shadow of the URI being parsed
  logic [7:0]  uri_chars [MaxUriChars];
  logic [7:0]  seg_lens  [MaxComponents];
  int unsigned uri_len   = 0;
  int unsigned seg_cnt   = 0;
  int unsigned seg_len   = 0;
  int unsigned body_len  = 0;
  esc_e        esc_state = EscNone;
  bit          uri_bad   = 1'b0;

  logic [7:0]  tlv_bytes[$];
  out_beat_t   expected_words[$];
  int unsigned mismatches = 0;

  // Traffic shaping knobs
  int unsigned gap_max     = 3;
  int unsigned burst_max   = 8;
  int unsigned burst_left  = 0;
  int unsigned stall_pct   = 30;
  int unsigned hold_cycles = 0;
  int unsigned hold_seq    = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;

  text_t draft;

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%s", msg);
  endfunction

  function automatic bit is_hex_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (!is_hex_digit(c)) return 4'd0;
    if (c <= 8'h39) return c[3:0];
    return c[3:0] + 4'd9;  // letters: low nibble 1..6 maps to 10..15
  endfunction

  function automatic int unsigned len_bytes(input int unsigned n);
    return (n < 253) ? 1 : 3;
  endfunction

  function automatic void reset_uri();
    uri_len   = 0;
    seg_cnt   = 0;
    seg_len   = 0;
    body_len  = 0;
    esc_state = EscNone;
    uri_bad   = 1'b0;
  endfunction

  function automatic void close_segment();
    if (seg_cnt >= MaxComponents) begin
      uri_bad = 1'b1;
      return;
    end
    seg_lens[seg_cnt] = 8'(seg_len);
    seg_cnt++;
    body_len += 1 + len_bytes(seg_len) + seg_len;
    seg_len = 0;
  endfunction

  // Length field: one byte, or marker plus 16-bit big-endian value
  function automatic void put_len(input int unsigned n);
    if (n < 253) begin
      tlv_bytes.push_back(8'(n));
    end else begin
      tlv_bytes.push_back(VarMarker);
      tlv_bytes.push_back(8'(n >> 8));
      tlv_bytes.push_back(8'(n));
    end
  endfunction

  function automatic logic [7:0] char_at(input int unsigned k);
    return (k < uri_len) ? uri_chars[k] : 8'h00;
  endfunction

  // Close the URI and queue the expected output beats
  function automatic void encode_name();
    out_beat_t   beat;
    int unsigned k;
    int unsigned nb;
    logic [7:0]  ch;
    if (esc_state != EscNone) uri_bad = 1'b1;
    if (!uri_bad && seg_len > 0) close_segment();
    if (!uri_bad && (body_len + 1 + len_bytes(body_len) > space_cfg)) uri_bad = 1'b1;
    if (uri_bad) begin
      beat = '0;
      beat.last_word = 1'b1;
      beat.status = 1'b1;
      expected_words.push_back(beat);
      reset_uri();
      return;
    end
    tlv_bytes.delete();
    tlv_bytes.push_back(name_type_cfg);
    put_len(body_len);
    k = 1;
    for (int unsigned s = 0; s < seg_cnt; s++) begin
      tlv_bytes.push_back(comp_type_cfg);
      put_len(seg_lens[s]);
      for (int unsigned n = 0; n < seg_lens[s]; n++) begin
        ch = char_at(k);
        if (ch == CharPercent) begin
          tlv_bytes.push_back({nibble_of(char_at(k + 1)), nibble_of(char_at(k + 2))});
          k += 3;
        end else begin
          tlv_bytes.push_back(ch);
          k++;
        end
      end
      k++;  // skip the separating slash
    end
    // pack into 8-byte beats, first byte lowest
    for (int unsigned i = 0; i < tlv_bytes.size(); i += 8) begin
      beat = '0;
      nb = 0;
      for (int unsigned j = 0; j < 8; j++) begin
        if (i + j < tlv_bytes.size()) begin
          beat.out_word[8*j +: 8] = tlv_bytes[i + j];
          nb++;
        end
      end
      beat.byte_count = 4'(nb);
      beat.last_word = (i + 8 >= tlv_bytes.size());
      expected_words.push_back(beat);
    end
    reset_uri();
  endfunction

  // Parser step for one accepted character beat
  function automatic void absorb_char(input in_beat_t b);
    if (!uri_bad) begin
      if (uri_len >= MaxUriChars) begin
        uri_bad = 1'b1;
      end else begin
        uri_chars[uri_len] = b.uri_char;
        uri_len++;
        if (uri_len == 1) begin
          if (b.uri_char != CharSlash) uri_bad = 1'b1;
        end else if (esc_state != EscNone) begin
          if (!is_hex_digit(b.uri_char)) uri_bad = 1'b1;
          else esc_state = (esc_state == EscFirst) ? EscSecond : EscNone;
        end else if (b.uri_char == CharSlash) begin
          if (seg_len == 0) uri_bad = 1'b1;
          else close_segment();
        end else begin
          if (seg_len == 255) uri_bad = 1'b1;
          else seg_len++;
          if (b.uri_char == CharPercent) esc_state = EscFirst;
        end
      end
    end
    if (b.last_char) encode_name();
  endfunction

  function automatic void check_word(input out_beat_t got);
    out_beat_t want;
    if (expected_words.size() == 0) begin
      note_failure($sformatf("unexpected beat: word=%h cnt=%0d last=%b status=%b",
                             got.out_word, got.byte_count, got.last_word, got.status));
      return;
    end
    want = expected_words.pop_front();
    if (got.out_word !== want.out_word || got.byte_count !== want.byte_count ||
        got.last_word !== want.last_word || got.status !== want.status) begin
      note_failure($sformatf({"beat mismatch: expected word=%h cnt=%0d last=%b status=%b,",
                              " got word=%h cnt=%0d last=%b status=%b"},
                             want.out_word, want.byte_count, want.last_word, want.status,
                             got.out_word, got.byte_count, got.last_word, got.status));
    end
  endfunction

  // Input monitor feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) absorb_char(in_data_i);
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_word(out_data_o);
  end

  // Receiver stall: random pattern, or a long hold when requested
  always @(posedge clk_i) begin
    if (hold_seq != rx_hold_seen) begin
      rx_hold_seen = hold_seq;
      rx_hold_left = hold_cycles;
    end
    if (rx_hold_left > 0) begin
      out_stall_i <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Stimulus helpers
  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CharSlash || c == CharPercent);
    return c;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex_digit(c));
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic void add_segment(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        draft.push_back(CharPercent);
        draft.push_back(hex_char());
        draft.push_back(hex_char());
      end else begin
        draft.push_back(rand_plain());
      end
    end
  endfunction

  function automatic text_t to_text(input string s);
    text_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Mostly well-formed names, some broken ones, a little raw noise
  function automatic text_t random_uri(output bit counts);
    int unsigned kind;
    int unsigned nseg;
    kind = $urandom_range(0, 99);
    draft.delete();
    draft.push_back(CharSlash);
    if (kind < 80) begin
      nseg = $urandom_range(0, 5);
      for (int unsigned s = 0; s < nseg; s++) begin
        if (s > 0) draft.push_back(CharSlash);
        add_segment($urandom_range(1, 6));
      end
      if (nseg > 0 && $urandom_range(0, 3) == 0) draft.push_back(CharSlash);
    end else if (kind < 92) begin
      add_segment($urandom_range(1, 4));
      case ($urandom_range(0, 3))
        0: begin
          // empty component
          draft.push_back(CharSlash);
          draft.push_back(CharSlash);
          add_segment(2);
        end
        1: begin
          // escape with a non-hex digit
          draft.push_back(CharPercent);
          if ($urandom_range(0, 1)) draft.push_back(hex_char());
          draft.push_back(non_hex());
          add_segment(1);
        end
        2: begin
          // name ends inside an escape
          draft.push_back(CharPercent);
          if ($urandom_range(0, 1)) draft.push_back(hex_char());
        end
        default: begin
          // missing leading slash
          do draft[0] = 8'($urandom_range(0, 255)); while (draft[0] == CharSlash);
        end
      endcase
    end else begin
      draft.delete();
      repeat ($urandom_range(1, 10)) draft.push_back(8'($urandom_range(0, 255)));
    end
    counts = (kind < 92);
    return draft;
  endfunction

  // One character beat, with bursty valid
  task automatic send_char(input logic [7:0] c, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= '{uri_char: c, last_char: last};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_text(input text_t t);
    for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
  endtask

  // Block is idle once all beats are out and the pipeline has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input reg_idx_e idx, input bit wr, input logic [PDataW-1:0] wdata,
                            output logic [PDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PAddrW'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register while idle, then read it back
  task automatic set_register(input reg_idx_e idx, input logic [PDataW-1:0] value);
    logic [PDataW-1:0] rdata;
    logic [PDataW-1:0] mask;
    wait_idle();
    apb_access(idx, 1'b1, value, rdata);
    case (idx)
      RegNameType: begin
        name_type_cfg = value[7:0];
        mask = 32'h0000_00FF;
      end
      RegCompType: begin
        comp_type_cfg = value[7:0];
        mask = 32'h0000_00FF;
      end
      default: begin
        space_cfg = value[SpaceW-1:0];
        mask = 32'h0000_03FF;
      end
    endcase
    apb_access(idx, 1'b0, '0, rdata);
    if ((rdata & mask) !== (value & mask)) begin
      note_failure($sformatf("register %s readback: expected %h, got %h",
                             idx.name(), value & mask, rdata & mask));
    end
  endtask

  // Valid forms: lone slash, trailing slash, escapes, character extremes
  task automatic test_name_forms();
    text_t t;
    send_text(to_text("/"));
    send_text(to_text("/a/b/"));
    send_text(to_text("/%41%7a"));
    t.push_back(CharSlash);
    t.push_back(8'h00);
    t.push_back(8'hFF);
    send_text(t);
    wait_idle();
  endtask

  // Bad start, empty component, non-hex escape, name ending in an escape
  task automatic test_malformed();
    send_text(to_text("a"));
    send_text(to_text("//"));
    send_text(to_text("/%g"));
    send_text(to_text("/%4"));
    wait_idle();
  endtask

  // Type codes at their extremes and the room limit around its edge
  task automatic test_register_settings();
    set_register(RegNameType, 32'd0);
    set_register(RegCompType, 32'd252);
    send_text(to_text("/ab/c"));
    set_register(RegNameType, 32'd252);
    set_register(RegCompType, 32'd0);
    send_text(to_text("/x"));
    // codes above the one-byte limit go out raw
    set_register(RegNameType, 32'd255);
    set_register(RegCompType, 32'd253);
    send_text(to_text("/q%2F"));
    // "/ab" needs exactly six bytes
    set_register(RegSpace, 32'd6);
    send_text(to_text("/ab"));
    set_register(RegSpace, 32'd5);
    send_text(to_text("/ab"));
    set_register(RegSpace, 32'd0);
    send_text(to_text("/"));
    set_register(RegNameType, 32'(NameTypeRst));
    set_register(RegCompType, 32'(CompTypeRst));
    set_register(RegSpace, 32'(SpaceRst));
  endtask

  // One component long enough for three-byte length fields in both TLVs
  task automatic test_length_limits();
    gap_max = 1;
    stall_pct = 40;
    draft.delete();
    draft.push_back(CharSlash);
    repeat (253) draft.push_back(rand_plain());
    send_text(draft);
    wait_idle();
  endtask

  // Hold the receiver off while names keep coming, so the input backs up
  task automatic test_backpressure();
    bit counts;
    stall_pct = 0;
    gap_max = 0;
    hold_cycles = 400;
    hold_seq++;
    for (int n = 0; n < 5; n++) begin
      do draft = random_uri(counts); while (draft.size() < 3 || draft[0] != CharSlash);
      send_text(draft);
    end
    wait_idle();
  endtask

  task automatic test_random_uris(input int unsigned budget);
    int unsigned sent;
    int unsigned names;
    bit          counts;
    text_t       t;
    sent = 0;
    names = 0;
    while (sent < budget) begin
      if (names % 4 == 3) begin
        set_register(RegNameType, 32'($urandom_range(0, 255)));
        set_register(RegCompType, 32'($urandom_range(0, 255)));
        case ($urandom_range(0, 4))
          0: set_register(RegSpace, 32'($urandom_range(0, 40)));
          1: set_register(RegSpace, 32'($urandom_range(0, 1023)));
          default: set_register(RegSpace, 32'(SpaceRst));
        endcase
      end
      if (names % 2 == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            gap_max = 0;
            stall_pct = 0;
          end
          1: begin
            gap_max = 2;
            stall_pct = 20;
          end
          2: begin
            gap_max = 6;
            stall_pct = 50;
          end
          default: begin
            gap_max = 1;
            stall_pct = 80;
          end
        endcase
        burst_max = $urandom_range(1, 12);
      end
      t = random_uri(counts);
      if (counts) sent += t.size();
      send_text(t);
      names++;
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_name_forms();
    test_malformed();
    test_register_settings();
    test_length_limits();
    test_backpressure();
    test_random_uris(70);
    wait_idle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
